>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on a rising clock, off while reset is asserted.
`define RMJ_ASSERT_MSG(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

// Same check with a generic message.
`define RMJ_ASSERT(name, clk, rstn, prop) \
  `RMJ_ASSERT_MSG(name, clk, rstn, prop, "rmj check failed")

`endif

>>> rtl/core/rmj_pkg.sv
// Shared types, constants and helper functions of the radar Jacobian block.
`timescale 1ns / 1ps
package rmj_pkg;

  localparam int Q_W       = 32;  // width of a quotient word
  localparam int SQ_CELLS  = 32;  // one root bit per cell
  localparam int DIV_CELLS = 32;  // one quotient bit per cell
  localparam int SQ_REM_W  = 34;  // root remainder stays below 2*root+1
  localparam int LANES     = 6;
  // input register, 3 front stages, root cells, 2 cube stages, divider cells, output
  localparam int PIPE_LAT  = 4 + SQ_CELLS + 2 + DIV_CELLS + 1;

  // data that rides beside the square root cells
  typedef struct packed {
    logic        degen;
    logic        nx;
    logic        ny;
    logic        dneg;
    logic        dpos;
    logic [31:0] apx;
    logic [31:0] apy;
    logic [63:0] r2;
    logic [95:0] n4;
    logic [95:0] n5;
  } pre_side_t;

  // data that rides beside the divider cells
  typedef struct packed {
    logic             degen;
    logic [LANES-1:0] ov;
    logic [LANES-1:0] neg;
  } div_side_t;

  // apply sign to a truncated quotient and clamp to the signed word range
  function automatic logic [Q_W-1:0] sat_word(logic [Q_W-1:0] q, logic ov, logic neg);
    logic [Q_W-1:0] res;
    if (neg) begin
      if (ov || (q > 32'h8000_0000)) res = 32'h8000_0000;
      else                           res = ~q + 32'd1;
    end else begin
      if (ov || q[Q_W-1]) res = 32'h7FFF_FFFF;
      else                res = q;
    end
    return res;
  endfunction

endpackage

>>> rtl/core/rmj_sqrt_cell.sv
// One cell of the integer square root chain: resolves one root bit.
`timescale 1ns / 1ps
module rmj_sqrt_cell import rmj_pkg::*; (
  input  logic                clk_i,
  input  logic [SQ_REM_W-1:0] rem_i,
  input  logic [31:0]         root_i,
  input  logic [63:0]         x_i,
  output logic [SQ_REM_W-1:0] rem_o,
  output logic [31:0]         root_o,
  output logic [63:0]         x_o
);

  logic [SQ_REM_W+1:0] t, trial, diff;
  logic                ge;
  logic [SQ_REM_W-1:0] rem_d, rem_q;
  logic [31:0]         root_d, root_q;
  logic [63:0]         x_d, x_q;

  always_comb begin
    t      = {rem_i, x_i[63:62]};
    trial  = {2'b00, root_i, 2'b01};
    ge     = (t >= trial);
    diff   = t - trial;
    rem_d  = ge ? diff[SQ_REM_W-1:0] : t[SQ_REM_W-1:0];
    root_d = {root_i[30:0], ge};
    x_d    = {x_i[61:0], 2'b00};
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    x_q    <= x_d;
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign x_o    = x_q;

endmodule

>>> rtl/core/rmj_div_cell.sv
// One cell of a restoring divider chain: resolves one quotient bit.
`timescale 1ns / 1ps
module rmj_div_cell import rmj_pkg::*; #(
  parameter int DEN_W = 32
) (
  input  logic             clk_i,
  input  logic [DEN_W-1:0] rem_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [Q_W-1:0]   nlo_i,
  input  logic [Q_W-1:0]   q_i,
  output logic [DEN_W-1:0] rem_o,
  output logic [DEN_W-1:0] den_o,
  output logic [Q_W-1:0]   nlo_o,
  output logic [Q_W-1:0]   q_o
);

  logic [DEN_W:0]   t, diff;
  logic             ge;
  logic [DEN_W-1:0] rem_d, rem_q, den_q;
  logic [Q_W-1:0]   nlo_d, nlo_q, q_d, q_q;

  always_comb begin
    t     = {rem_i, nlo_i[Q_W-1]};
    ge    = (t >= {1'b0, den_i});
    diff  = t - {1'b0, den_i};
    rem_d = ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
    q_d   = {q_i[Q_W-2:0], ge};
    nlo_d = {nlo_i[Q_W-2:0], 1'b0};
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_i;
    nlo_q <= nlo_d;
    q_q   <= q_d;
  end

  assign rem_o = rem_q;
  assign den_o = den_q;
  assign nlo_o = nlo_q;
  assign q_o   = q_q;

endmodule

>>> rtl/core/radar_measurement_jacobian.sv
// Top level: pipelined radar range/bearing/range-rate Jacobian.
//
//  channel   | ports                                      | handshake
//  ----------+--------------------------------------------+---------------------------
//  state in  | pos_x_i pos_y_i vel_x_i vel_y_i            | start_i while busy_o low
//  result    | range/bearing/rate_by_px/py_o degenerate_o | done_o, one cycle, no stall
//  config    | cfg_wdata_i (min_range_squared)            | cfg_we_i, no wait
//
//  One word is taken per cycle while busy_o is low. The pipe depth is set by the
//  input and front stages, 32 root cells, cube stages, 32 divider cells and output.
//  busy_o is high in reset and for the first cycle after it, then stays low.
//  done_o cannot be held off; results stream out in input order.
//  Reset clears the valid pipe and sets min_range_squared to 7.
`timescale 1ns / 1ps
module radar_measurement_jacobian import rmj_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  output logic               done_o,
  output logic signed [31:0] range_by_px_o,
  output logic signed [31:0] range_by_py_o,
  output logic signed [31:0] bearing_by_px_o,
  output logic signed [31:0] bearing_by_py_o,
  output logic signed [31:0] rate_by_px_o,
  output logic signed [31:0] rate_by_py_o,
  output logic               degenerate_o
);

  localparam int N01_W = 32 + FRAC_BITS;      // px << F
  localparam int N23_W = 32 + 2 * FRAC_BITS;  // py << 2F
  localparam int N45_W = 96 + FRAC_BITS;      // (py * D) << F

  // ---- control ----
  logic                busy_q;
  logic                acc;
  logic [15:0]         thr_q;
  logic [PIPE_LAT-1:0] vld_q;

  assign acc = start_i & ~busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      thr_q  <= 16'd7;
      vld_q  <= '0;
    end else begin
      busy_q <= 1'b0;
      if (cfg_we_i) thr_q <= cfg_wdata_i;
      vld_q <= {vld_q[PIPE_LAT-2:0], acc};
    end
  end

  // ---- stage 1: input word ----
  logic signed [31:0] px_q, py_q, vx_q, vy_q;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      px_q <= pos_x_i;
      py_q <= pos_y_i;
      vx_q <= vel_x_i;
      vy_q <= vel_y_i;
    end
  end

  // ---- stage 2: magnitudes, squares, cross products ----
  logic [31:0]        apx_d, apy_d, apx2_q, apy2_q;
  logic [63:0]        sqx_q, sqy_q;
  logic signed [63:0] a_q, b_q;
  logic               nx2_q, ny2_q;

  assign apx_d = px_q[31] ? (~px_q + 32'd1) : px_q;
  assign apy_d = py_q[31] ? (~py_q + 32'd1) : py_q;

  always_ff @(posedge clk_i) begin
    apx2_q <= apx_d;
    apy2_q <= apy_d;
    sqx_q  <= {32'd0, apx_d} * {32'd0, apx_d};
    sqy_q  <= {32'd0, apy_d} * {32'd0, apy_d};
    a_q    <= 64'(vx_q) * 64'(py_q);
    b_q    <= 64'(vy_q) * 64'(px_q);
    nx2_q  <= px_q[31];
    ny2_q  <= py_q[31];
  end

  // ---- stage 3: r2 and D = vx*py - vy*px as sign and magnitude ----
  logic signed [64:0] dif_c, ndif_c;
  logic [63:0]        r2_3q, dmag_3q;
  logic               dneg_3q, dpos_3q, nx3_q, ny3_q;
  logic [31:0]        apx3_q, apy3_q;

  assign dif_c  = 65'(a_q) - 65'(b_q);
  assign ndif_c = -dif_c;

  always_ff @(posedge clk_i) begin
    r2_3q   <= sqx_q + sqy_q;
    dmag_3q <= dif_c[64] ? ndif_c[63:0] : dif_c[63:0];
    dneg_3q <= dif_c[64];
    dpos_3q <= ~dif_c[64] & (dif_c != '0);
    apx3_q  <= apx2_q;
    apy3_q  <= apy2_q;
    nx3_q   <= nx2_q;
    ny3_q   <= ny2_q;
  end

  // ---- stage 4: numerator partial products, near-origin test ----
  logic [63:0] pyl_q, pyh_q, pxl_q, pxh_q, r2_4q, thr_ext;
  logic        dneg_4q, dpos_4q, nx4_q, ny4_q, degen_4q;
  logic [31:0] apx4_q, apy4_q;

  assign thr_ext = 64'({thr_q, {FRAC_BITS{1'b0}}});

  always_ff @(posedge clk_i) begin
    pyl_q    <= {32'd0, apy3_q} * {32'd0, dmag_3q[31:0]};
    pyh_q    <= {32'd0, apy3_q} * {32'd0, dmag_3q[63:32]};
    pxl_q    <= {32'd0, apx3_q} * {32'd0, dmag_3q[31:0]};
    pxh_q    <= {32'd0, apx3_q} * {32'd0, dmag_3q[63:32]};
    degen_4q <= (r2_3q == '0) || (r2_3q < thr_ext);
    r2_4q    <= r2_3q;
    apx4_q   <= apx3_q;
    apy4_q   <= apy3_q;
    dneg_4q  <= dneg_3q;
    dpos_4q  <= dpos_3q;
    nx4_q    <= nx3_q;
    ny4_q    <= ny3_q;
  end

  // ---- square root chain, side data delayed alongside ----
  logic [SQ_REM_W-1:0] sq_rem  [SQ_CELLS+1];
  logic [31:0]         sq_root [SQ_CELLS+1];
  logic [63:0]         sq_x    [SQ_CELLS+1];
  pre_side_t           side_in;
  pre_side_t           side_q  [SQ_CELLS];

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_x[0]    = r2_4q;

  always_comb begin
    side_in.degen = degen_4q;
    side_in.nx    = nx4_q;
    side_in.ny    = ny4_q;
    side_in.dneg  = dneg_4q;
    side_in.dpos  = dpos_4q;
    side_in.apx   = apx4_q;
    side_in.apy   = apy4_q;
    side_in.r2    = r2_4q;
    side_in.n4    = {32'd0, pyl_q} + {pyh_q, 32'd0};
    side_in.n5    = {32'd0, pxl_q} + {pxh_q, 32'd0};
  end

  for (genvar c = 0; c < SQ_CELLS; c++) begin : g_sq
    rmj_sqrt_cell u_cell (
      .clk_i,
      .rem_i  (sq_rem[c]),
      .root_i (sq_root[c]),
      .x_i    (sq_x[c]),
      .rem_o  (sq_rem[c+1]),
      .root_o (sq_root[c+1]),
      .x_o    (sq_x[c+1])
    );
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_in;
    for (int k = 1; k < SQ_CELLS; k++) side_q[k] <= side_q[k-1];
  end

  // ---- r3 = r2 * r in two halves, then summed ----
  logic [31:0] r_aq, r_bq;
  logic [63:0] r3l_q, r3h_q;
  logic [95:0] r3_bq;
  pre_side_t   side_aq, side_bq;

  always_ff @(posedge clk_i) begin
    r_aq    <= sq_root[SQ_CELLS];
    r3l_q   <= {32'd0, side_q[SQ_CELLS-1].r2[31:0]} * {32'd0, sq_root[SQ_CELLS]};
    r3h_q   <= {32'd0, side_q[SQ_CELLS-1].r2[63:32]} * {32'd0, sq_root[SQ_CELLS]};
    side_aq <= side_q[SQ_CELLS-1];
    r_bq    <= r_aq;
    r3_bq   <= {32'd0, r3l_q} + {r3h_q, 32'd0};
    side_bq <= side_aq;
  end

  // ---- lane setup: high numerator part seeds the remainder ----
  logic [N01_W-1:0] n0_c, n1_c;
  logic [N23_W-1:0] n2_c, n3_c;
  logic [N45_W-1:0] n4_c, n5_c;
  logic [31:0]      hi0_c, hi1_c;
  logic [63:0]      hi2_c, hi3_c;
  logic [95:0]      hi4_c, hi5_c;
  div_side_t        dside_in;

  always_comb begin
    n0_c = {side_bq.apx, {FRAC_BITS{1'b0}}};
    n1_c = {side_bq.apy, {FRAC_BITS{1'b0}}};
    n2_c = {side_bq.apy, {(2 * FRAC_BITS){1'b0}}};
    n3_c = {side_bq.apx, {(2 * FRAC_BITS){1'b0}}};
    n4_c = {side_bq.n4, {FRAC_BITS{1'b0}}};
    n5_c = {side_bq.n5, {FRAC_BITS{1'b0}}};
    hi0_c = 32'(n0_c[N01_W-1:Q_W]);
    hi1_c = 32'(n1_c[N01_W-1:Q_W]);
    hi2_c = 64'(n2_c[N23_W-1:Q_W]);
    hi3_c = 64'(n3_c[N23_W-1:Q_W]);
    hi4_c = 96'(n4_c[N45_W-1:Q_W]);
    hi5_c = 96'(n5_c[N45_W-1:Q_W]);
    // quotient reaches 2^32 or more: clamp at the end
    dside_in.degen = side_bq.degen;
    dside_in.ov    = {hi5_c >= r3_bq, hi4_c >= r3_bq,
                      hi3_c >= side_bq.r2, hi2_c >= side_bq.r2,
                      hi1_c >= r_bq, hi0_c >= r_bq};
    dside_in.neg   = {side_bq.nx ^ side_bq.dpos,
                      side_bq.ny ^ side_bq.dneg,
                      side_bq.nx,
                      ~side_bq.ny & (side_bq.apy != '0),
                      side_bq.ny,
                      side_bq.nx};
  end

  // ---- divider chains, one lane per Jacobian entry ----
  logic [31:0]    d32_rem [2][DIV_CELLS+1];
  logic [31:0]    d32_den [2][DIV_CELLS+1];
  logic [63:0]    d64_rem [2][DIV_CELLS+1];
  logic [63:0]    d64_den [2][DIV_CELLS+1];
  logic [95:0]    d96_rem [2][DIV_CELLS+1];
  logic [95:0]    d96_den [2][DIV_CELLS+1];
  logic [Q_W-1:0] nlo     [LANES][DIV_CELLS+1];
  logic [Q_W-1:0] quo     [LANES][DIV_CELLS+1];
  div_side_t      dside_q [DIV_CELLS];

  assign d32_rem[0][0] = hi0_c;
  assign d32_rem[1][0] = hi1_c;
  assign d32_den[0][0] = r_bq;
  assign d32_den[1][0] = r_bq;
  assign d64_rem[0][0] = hi2_c;
  assign d64_rem[1][0] = hi3_c;
  assign d64_den[0][0] = side_bq.r2;
  assign d64_den[1][0] = side_bq.r2;
  assign d96_rem[0][0] = hi4_c;
  assign d96_rem[1][0] = hi5_c;
  assign d96_den[0][0] = r3_bq;
  assign d96_den[1][0] = r3_bq;
  assign nlo[0][0] = n0_c[Q_W-1:0];
  assign nlo[1][0] = n1_c[Q_W-1:0];
  assign nlo[2][0] = n2_c[Q_W-1:0];
  assign nlo[3][0] = n3_c[Q_W-1:0];
  assign nlo[4][0] = n4_c[Q_W-1:0];
  assign nlo[5][0] = n5_c[Q_W-1:0];

  for (genvar l = 0; l < LANES; l++) begin : g_q0
    assign quo[l][0] = '0;
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    for (genvar c = 0; c < DIV_CELLS; c++) begin : g_cell
      rmj_div_cell #(.DEN_W(32)) u_r (
        .clk_i,
        .rem_i (d32_rem[l][c]),   .den_i (d32_den[l][c]),
        .nlo_i (nlo[l][c]),       .q_i   (quo[l][c]),
        .rem_o (d32_rem[l][c+1]), .den_o (d32_den[l][c+1]),
        .nlo_o (nlo[l][c+1]),     .q_o   (quo[l][c+1])
      );
      rmj_div_cell #(.DEN_W(64)) u_b (
        .clk_i,
        .rem_i (d64_rem[l][c]),   .den_i (d64_den[l][c]),
        .nlo_i (nlo[l+2][c]),     .q_i   (quo[l+2][c]),
        .rem_o (d64_rem[l][c+1]), .den_o (d64_den[l][c+1]),
        .nlo_o (nlo[l+2][c+1]),   .q_o   (quo[l+2][c+1])
      );
      rmj_div_cell #(.DEN_W(96)) u_rr (
        .clk_i,
        .rem_i (d96_rem[l][c]),   .den_i (d96_den[l][c]),
        .nlo_i (nlo[l+4][c]),     .q_i   (quo[l+4][c]),
        .rem_o (d96_rem[l][c+1]), .den_o (d96_den[l][c+1]),
        .nlo_o (nlo[l+4][c+1]),   .q_o   (quo[l+4][c+1])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    dside_q[0] <= dside_in;
    for (int k = 1; k < DIV_CELLS; k++) dside_q[k] <= dside_q[k-1];
  end

  // ---- output word: sign, clamp, zero near the origin ----
  logic [Q_W-1:0] res_q [LANES];
  logic           degen_q;
  div_side_t      dend;

  assign dend = dside_q[DIV_CELLS-1];

  always_ff @(posedge clk_i) begin
    degen_q <= dend.degen;
    for (int k = 0; k < LANES; k++) begin
      res_q[k] <= dend.degen ? '0 : sat_word(quo[k][DIV_CELLS], dend.ov[k], dend.neg[k]);
    end
  end

  assign busy_o          = busy_q;
  assign done_o          = vld_q[PIPE_LAT-1];
  assign range_by_px_o   = $signed(res_q[0]);
  assign range_by_py_o   = $signed(res_q[1]);
  assign bearing_by_px_o = $signed(res_q[2]);
  assign bearing_by_py_o = $signed(res_q[3]);
  assign rate_by_px_o    = $signed(res_q[4]);
  assign rate_by_py_o    = $signed(res_q[5]);
  assign degenerate_o    = degen_q;

endmodule

>>> rtl/core/rmj_checker.sv
// Port-level checks of the radar Jacobian block, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rmj_checker import rmj_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               done_o,
  input logic               degenerate_o,
  input logic signed [31:0] range_by_px_o,
  input logic signed [31:0] range_by_py_o,
  input logic signed [31:0] bearing_by_px_o,
  input logic signed [31:0] bearing_by_py_o,
  input logic signed [31:0] rate_by_px_o,
  input logic signed [31:0] rate_by_py_o
);

  logic acc;
  logic all_zero;

  assign acc      = start_i && !busy_o;
  assign all_zero = (range_by_px_o == '0) && (range_by_py_o == '0) &&
                    (bearing_by_px_o == '0) && (bearing_by_py_o == '0) &&
                    (rate_by_px_o == '0) && (rate_by_py_o == '0);

  // every taken word comes out after the fixed pipe depth, and nothing else does
  `RMJ_ASSERT_MSG(a_word_out, clk_i, rst_ni, acc |-> ##PIPE_LAT done_o, "word lost")
  `RMJ_ASSERT_MSG(a_no_extra, clk_i, rst_ni, done_o |-> $past(acc, PIPE_LAT), "extra word")
  // near the origin every entry is zero
  `RMJ_ASSERT(a_degen_zero, clk_i, rst_ni, (done_o && degenerate_o) |-> all_zero)

endmodule

bind radar_measurement_jacobian rmj_checker u_rmj_checker (.*);
